// File: rtl/rcdbus_pkg.sv
// ----------------------------------------------------------------------------
// rcdbus_pkg
// Shared types, widths and codes of the remote-control bus frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcdbus_pkg;

	// Frame geometry
	localparam int FRAME_BYTES   = 18;
	localparam int BYTE_W        = 8;
	localparam int FRAME_COUNT_W = 5;
	localparam int IDLE_COUNT_W  = 8;

	// Channel arithmetic
	localparam int RAW_W  = 11;
	localparam int CHAN_W = 12;
	localparam int WORD_W = 16;
	localparam int SW_W   = 4;
	localparam logic [WORD_W-1:0] WHEEL_OFFSET = 16'd1024;

	// Configuration register widths and reset values
	localparam int IDLE_LIMIT_W = 8;
	localparam int DEAD_BAND_W  = 10;
	localparam int LIMIT_W      = 11;
	localparam int CENTER_W     = 11;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 11;

	localparam logic [IDLE_LIMIT_W-1:0] IDLE_LIMIT_RST = 8'd10;
	localparam logic [DEAD_BAND_W-1:0]  DEAD_BAND_RST  = 10'd10;
	localparam logic [LIMIT_W-1:0]      LIMIT_RST      = 11'd660;
	localparam logic [CENTER_W-1:0]     CENTER_RST     = 11'd1024;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_LIMIT     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_BAND      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_LIMIT  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_CENTER = 2'd3;

	// Status codes
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

	// Input item kinds
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_IDLE = 1'b1;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Output payload width, padded to whole bytes
	localparam int OUT_BITS   = 4 * CHAN_W + SW_W + 6 * WORD_W + STATUS_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] window_t;

	// One finished frame as handed from front to back
	typedef struct packed {
		logic    short_frame;
		window_t bytes;
	} frame_t;

	// Live configuration
	typedef struct packed {
		logic [IDLE_LIMIT_W-1:0] idle_limit;
		logic [DEAD_BAND_W-1:0]  dead_band;
		logic [LIMIT_W-1:0]      channel_limit;
		logic [CENTER_W-1:0]     channel_center;
	} cfg_t;

	// Decoded result
	typedef struct packed {
		logic signed [CHAN_W-1:0] stick_right_x;
		logic signed [CHAN_W-1:0] stick_right_y;
		logic signed [CHAN_W-1:0] stick_left_x;
		logic signed [CHAN_W-1:0] stick_left_y;
		logic [SW_W-1:0]          switches;
		logic signed [WORD_W-1:0] mouse_x;
		logic signed [WORD_W-1:0] mouse_y;
		logic signed [WORD_W-1:0] mouse_z;
		logic [WORD_W-1:0]        mouse_buttons;
		logic [WORD_W-1:0]        key_bits;
		logic signed [WORD_W-1:0] wheel_value;
		logic [STATUS_W-1:0]      status;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/rcdbus_front.sv
// ----------------------------------------------------------------------------
// rcdbus_front
// Accepts bytes and idle ticks, keeps the byte window and counters, and
// pushes a snapshot of the window into the queue at each frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdbus_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	input  wire logic                                   in_op,
	input  wire logic [rcdbus_pkg::BYTE_W-1:0]          in_byte,
	output logic                                        in_ready,
	input  wire logic [rcdbus_pkg::IDLE_LIMIT_W-1:0]    idle_limit,
	output logic                                        push,
	output rcdbus_pkg::frame_t                          push_frame,
	input  wire logic                                   queue_full
);

	rcdbus_pkg::window_t                           win_q;
	logic [rcdbus_pkg::FRAME_COUNT_W-1:0]          count_q;
	logic [rcdbus_pkg::IDLE_COUNT_W-1:0]           idle_q;
	logic [rcdbus_pkg::IDLE_COUNT_W-1:0]           idle_next;
	logic                                          accept;
	logic                                          frame_end;

	// Stall the input only while the queue has no room
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Saturating idle count and frame end detection
	always_comb begin
		idle_next = (idle_q == '1) ? idle_q : idle_q + 1'b1;
		frame_end = accept && (in_op == rcdbus_pkg::OP_IDLE) && (idle_next >= idle_limit);
	end

	assign push                   = frame_end;
	assign push_frame.bytes       = win_q;
	assign push_frame.short_frame =
		(count_q < rcdbus_pkg::FRAME_COUNT_W'(rcdbus_pkg::FRAME_BYTES));

	// Window: oldest byte at index zero, newest shifted in at the top
	always_ff @(posedge clk) begin
		if (accept && (in_op == rcdbus_pkg::OP_BYTE)) begin
			win_q <= {in_byte, win_q[rcdbus_pkg::FRAME_BYTES-1:1]};
		end
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idle_q  <= '0;
		end else if (accept) begin
			if (in_op == rcdbus_pkg::OP_BYTE) begin
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
				idle_q <= '0;
			end else if (frame_end) begin
				count_q <= '0;
				idle_q  <= '0;
			end else begin
				idle_q <= idle_next;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rcdbus_fifo.sv
// ----------------------------------------------------------------------------
// rcdbus_fifo
// Short queue of finished frames between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdbus_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire rcdbus_pkg::frame_t push_frame,
	input  wire logic               pop,
	output rcdbus_pkg::frame_t      head,
	output logic                    empty,
	output logic                    full
);

	rcdbus_pkg::frame_t                        slot_q [rcdbus_pkg::QUEUE_DEPTH];
	logic [rcdbus_pkg::QUEUE_PTR_W-1:0]        wr_q;
	logic [rcdbus_pkg::QUEUE_PTR_W-1:0]        rd_q;
	logic [rcdbus_pkg::QUEUE_CNT_W-1:0]        cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == rcdbus_pkg::QUEUE_CNT_W'(rcdbus_pkg::QUEUE_DEPTH));
	assign head  = slot_q[rd_q];

	// Store an item at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_frame;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == rcdbus_pkg::QUEUE_PTR_W'(rcdbus_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == rcdbus_pkg::QUEUE_PTR_W'(rcdbus_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rcdbus_back.sv
// ----------------------------------------------------------------------------
// rcdbus_back
// Decodes one queued frame per cycle into the output register while that is
// free or being taken, and keeps the held mouse, button, key and wheel values.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdbus_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire rcdbus_pkg::cfg_t       cfg,
	input  wire rcdbus_pkg::frame_t     head,
	input  wire logic                   empty,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output rcdbus_pkg::result_t         out_data
);

	typedef struct packed {
		logic signed [rcdbus_pkg::CHAN_W-1:0] value;
		logic                                 bad;
	} chan_t;

	logic                                   valid_q;
	rcdbus_pkg::result_t                    out_q;
	logic [rcdbus_pkg::WORD_W-1:0]          held_mx_q;
	logic [rcdbus_pkg::WORD_W-1:0]          held_my_q;
	logic [rcdbus_pkg::WORD_W-1:0]          held_mz_q;
	logic [rcdbus_pkg::WORD_W-1:0]          held_btn_q;
	logic [rcdbus_pkg::WORD_W-1:0]          held_key_q;
	logic [rcdbus_pkg::WORD_W-1:0]          held_whl_q;
	rcdbus_pkg::window_t                    w;
	chan_t                                  ch0, ch1, ch2, ch3;
	logic                                   bad;
	logic [rcdbus_pkg::WORD_W-1:0]          new_mx, new_my, new_mz;
	logic [rcdbus_pkg::WORD_W-1:0]          new_btn, new_key, new_whl;
	rcdbus_pkg::result_t                    res;

	// Centre one raw channel, apply the deadband and check the limit
	function automatic chan_t centre(
		input logic [rcdbus_pkg::RAW_W-1:0]       raw,
		input logic [rcdbus_pkg::CENTER_W-1:0]    ctr,
		input logic [rcdbus_pkg::DEAD_BAND_W-1:0] db,
		input logic [rcdbus_pkg::LIMIT_W-1:0]     lim
	);
		chan_t                                r;
		logic signed [rcdbus_pkg::CHAN_W-1:0] v;
		logic [rcdbus_pkg::RAW_W-1:0]         mag;
		v   = $signed({1'b0, raw}) - $signed({1'b0, ctr});
		mag = v[rcdbus_pkg::CHAN_W-1] ? rcdbus_pkg::RAW_W'(-v) : v[rcdbus_pkg::RAW_W-1:0];
		if (mag <= {1'b0, db}) begin
			v   = '0;
			mag = '0;
		end
		r.value = v;
		r.bad   = (mag > lim);
		return r;
	endfunction

	assign pop       = !empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = out_q;
	assign w         = head.bytes;

	// Unpack channels and words
	always_comb begin
		ch0 = centre({w[1][2:0], w[0]}, cfg.channel_center, cfg.dead_band,
			cfg.channel_limit);
		ch1 = centre({w[2][5:0], w[1][7:3]}, cfg.channel_center, cfg.dead_band,
			cfg.channel_limit);
		ch2 = centre({w[4][0], w[3], w[2][7:6]}, cfg.channel_center, cfg.dead_band,
			cfg.channel_limit);
		ch3 = centre({w[5][3:0], w[4][7:1]}, cfg.channel_center, cfg.dead_band,
			cfg.channel_limit);
		bad     = ch0.bad || ch1.bad || ch2.bad || ch3.bad;
		new_mx  = {w[7], w[6]};
		new_my  = {w[9], w[8]};
		new_mz  = {w[11], w[10]};
		new_btn = {w[13], w[12]};
		new_key = {w[15], w[14]};
		new_whl = {w[17], w[16]} - rcdbus_pkg::WHEEL_OFFSET;
	end

	// Build the result
	always_comb begin
		res = '0;
		if (head.short_frame) begin
			res.status = rcdbus_pkg::STATUS_SHORT;
		end else begin
			res.stick_right_x = ch0.value;
			res.stick_right_y = ch1.value;
			res.stick_left_x  = ch2.value;
			res.stick_left_y  = ch3.value;
			res.switches      = w[5][7:4];
			if (bad) begin
				res.mouse_x       = held_mx_q;
				res.mouse_y       = held_my_q;
				res.mouse_z       = held_mz_q;
				res.mouse_buttons = held_btn_q;
				res.key_bits      = held_key_q;
				res.wheel_value   = held_whl_q;
				res.status        = rcdbus_pkg::STATUS_RANGE;
			end else begin
				res.mouse_x       = new_mx;
				res.mouse_y       = new_my;
				res.mouse_z       = new_mz;
				res.mouse_buttons = new_btn;
				res.key_bits      = new_key;
				res.wheel_value   = new_whl;
				res.status        = rcdbus_pkg::STATUS_OK;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	// Output valid and held values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			held_mx_q  <= '0;
			held_my_q  <= '0;
			held_mz_q  <= '0;
			held_btn_q <= '0;
			held_key_q <= '0;
			held_whl_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (pop && (head.short_frame || !bad)) begin
				held_mx_q  <= res.mouse_x;
				held_my_q  <= res.mouse_y;
				held_mz_q  <= res.mouse_z;
				held_btn_q <= res.mouse_buttons;
				held_key_q <= res.key_bits;
				held_whl_q <= res.wheel_value;
			end
		end
	end

	// A frame leaves the queue only when the output register can take it
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!empty && (!valid_q || out_ready)))
		else $error("frame popped while output register blocked");

	// A short frame shows every field but the status zero
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_q.status == rcdbus_pkg::STATUS_SHORT) |->
		(out_q.mouse_x == '0 && out_q.stick_right_x == '0 && out_q.key_bits == '0))
		else $error("short frame result not zeroed");

	// A short frame clears the held values
	a_short_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.short_frame) |=> (held_mx_q == '0 && held_whl_q == '0))
		else $error("held values not cleared after short frame");

	// An out-of-range frame repeats the held values
	a_range_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !head.short_frame && bad) |=>
		(out_q.mouse_x == $past(held_mx_q) && $stable(held_key_q)))
		else $error("held values not kept on out-of-range frame");

endmodule

`default_nettype wire

// File: rtl/rc_dbus_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// rc_dbus_frame_decoder_top
// Remote-control bus frame decoder: byte and idle-tick stream in, one decoded
// frame out per run of idle ticks reaching the idle limit.
// ----------------------------------------------------------------------------
// The block takes one input item (a byte or an idle tick) every clock cycle
// while s_tready is high. The front keeps the 18-byte window and counters
// and, on the idle tick that ends a frame, places a window snapshot into a
// two-entry queue; the back decodes the head of that queue combinationally
// into the output register, so a result reaches the master side through the
// queue slot register and then the output register. s_tready drops only
// while the queue holds two frames behind a result that the master side
// has not yet taken, so a master-side stall has to span three frame ends
// before the input stalls.
// There is no clearing pass after reset.
`default_nettype none

module rc_dbus_frame_decoder_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Input stream
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [7:0]                            s_tdata,   // [7:0] byte_value
	input  wire logic [0:0]                            s_tuser,   // [0] op
	// Result stream
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// [11:0] stick_right_x, [23:12] stick_right_y, [35:24] stick_left_x,
	// [47:36] stick_left_y, [51:48] switches, [67:52] mouse_x, [83:68] mouse_y,
	// [99:84] mouse_z, [115:100] mouse_buttons, [131:116] key_bits,
	// [147:132] wheel_value, [149:148] status, [151:150] zero
	output logic [rcdbus_pkg::OUT_DATA_W-1:0]          m_tdata,
	// Configuration writes
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [rcdbus_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [rcdbus_pkg::CFG_DATA_W-1:0]     cfg_data
);

	rcdbus_pkg::cfg_t       cfg_q;
	rcdbus_pkg::frame_t     push_frame;
	rcdbus_pkg::frame_t     head;
	rcdbus_pkg::result_t    res;
	logic                   push;
	logic                   pop;
	logic                   empty;
	logic                   full;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_limit     <= rcdbus_pkg::IDLE_LIMIT_RST;
			cfg_q.dead_band      <= rcdbus_pkg::DEAD_BAND_RST;
			cfg_q.channel_limit  <= rcdbus_pkg::LIMIT_RST;
			cfg_q.channel_center <= rcdbus_pkg::CENTER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rcdbus_pkg::CFG_IDLE_LIMIT: begin
					cfg_q.idle_limit <= cfg_data[rcdbus_pkg::IDLE_LIMIT_W-1:0];
				end
				rcdbus_pkg::CFG_DEAD_BAND: begin
					cfg_q.dead_band <= cfg_data[rcdbus_pkg::DEAD_BAND_W-1:0];
				end
				rcdbus_pkg::CFG_CHANNEL_LIMIT: begin
					cfg_q.channel_limit <= cfg_data[rcdbus_pkg::LIMIT_W-1:0];
				end
				rcdbus_pkg::CFG_CHANNEL_CENTER: begin
					cfg_q.channel_center <= cfg_data[rcdbus_pkg::CENTER_W-1:0];
				end
			endcase
		end
	end

	rcdbus_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_op      (s_tuser[0]),
		.in_byte    (s_tdata),
		.in_ready   (s_tready),
		.idle_limit (cfg_q.idle_limit),
		.push       (push),
		.push_frame (push_frame),
		.queue_full (full)
	);

	rcdbus_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	rcdbus_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	// Pack the result, first field lowest
	assign m_tdata = rcdbus_pkg::OUT_DATA_W'({
		res.status, res.wheel_value, res.key_bits, res.mouse_buttons,
		res.mouse_z, res.mouse_y, res.mouse_x, res.switches,
		res.stick_left_y, res.stick_left_x, res.stick_right_y, res.stick_right_x
	});

endmodule

`default_nettype wire
